/* rtl/core/dsb_pkg.sv */
// shared constants, types and sine table for the dds sine burst generator
package dsb_pkg;

    localparam int PHASE_BITS_DEF    = 32;
    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int INC_BITS      = 32;
    localparam int CNT_BITS      = 8;
    localparam int ROM_ADDR_BITS = 8;
    localparam int ROM_POINTS    = 1 << ROM_ADDR_BITS;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_TICKS_MS  = 2'd1;
    localparam logic [1:0] REG_PERIOD_MS = 2'd2;
    localparam logic [1:0] REG_BURST_MS  = 2'd3;

    localparam logic [INC_BITS-1:0] PHASE_INC_RESET = 32'd68719000;
    localparam logic [CNT_BITS-1:0] TICKS_MS_RESET  = 8'd62;
    localparam logic [CNT_BITS-1:0] PERIOD_MS_RESET = 8'd50;
    localparam logic [CNT_BITS-1:0] BURST_MS_RESET  = 8'd15;
    localparam logic [7:0]          DUTY_MID        = 8'd128;

    typedef struct packed {
        logic [INC_BITS-1:0] phase_increment;
        logic [CNT_BITS-1:0] ticks_per_ms;
        logic [CNT_BITS-1:0] period_ms;
        logic [CNT_BITS-1:0] burst_ms;
    } dsb_cfg_t;

    // truncated 127*sin(6.283*i/256)
    localparam logic signed [7:0] SINE_ROM [0:ROM_POINTS-1] = '{
        8'sd0, 8'sd3, 8'sd6, 8'sd9, 8'sd12, 8'sd15, 8'sd18, 8'sd21,
        8'sd24, 8'sd27, 8'sd30, 8'sd33, 8'sd36, 8'sd39, 8'sd42, 8'sd45,
        8'sd48, 8'sd51, 8'sd54, 8'sd57, 8'sd59, 8'sd62, 8'sd65, 8'sd67,
        8'sd70, 8'sd73, 8'sd75, 8'sd78, 8'sd80, 8'sd82, 8'sd85, 8'sd87,
        8'sd89, 8'sd91, 8'sd94, 8'sd96, 8'sd98, 8'sd100, 8'sd102, 8'sd103,
        8'sd105, 8'sd107, 8'sd108, 8'sd110, 8'sd112, 8'sd113, 8'sd114, 8'sd116,
        8'sd117, 8'sd118, 8'sd119, 8'sd120, 8'sd121, 8'sd122, 8'sd123, 8'sd123,
        8'sd124, 8'sd125, 8'sd125, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126,
        8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd126, 8'sd125, 8'sd125,
        8'sd124, 8'sd123, 8'sd123, 8'sd122, 8'sd121, 8'sd120, 8'sd119, 8'sd118,
        8'sd117, 8'sd116, 8'sd114, 8'sd113, 8'sd112, 8'sd110, 8'sd108, 8'sd107,
        8'sd105, 8'sd103, 8'sd102, 8'sd100, 8'sd98, 8'sd96, 8'sd94, 8'sd91,
        8'sd89, 8'sd87, 8'sd85, 8'sd82, 8'sd80, 8'sd78, 8'sd75, 8'sd73,
        8'sd70, 8'sd67, 8'sd65, 8'sd62, 8'sd59, 8'sd57, 8'sd54, 8'sd51,
        8'sd48, 8'sd45, 8'sd42, 8'sd39, 8'sd36, 8'sd33, 8'sd30, 8'sd27,
        8'sd24, 8'sd21, 8'sd18, 8'sd15, 8'sd12, 8'sd9, 8'sd6, 8'sd3,
        8'sd0, -8'sd3, -8'sd6, -8'sd9, -8'sd12, -8'sd15, -8'sd18, -8'sd21,
        -8'sd24, -8'sd27, -8'sd30, -8'sd33, -8'sd36, -8'sd39, -8'sd42, -8'sd45,
        -8'sd48, -8'sd51, -8'sd54, -8'sd57, -8'sd59, -8'sd62, -8'sd65, -8'sd67,
        -8'sd70, -8'sd73, -8'sd75, -8'sd78, -8'sd80, -8'sd82, -8'sd85, -8'sd87,
        -8'sd89, -8'sd91, -8'sd94, -8'sd96, -8'sd98, -8'sd100, -8'sd101, -8'sd103,
        -8'sd105, -8'sd107, -8'sd108, -8'sd110, -8'sd111, -8'sd113, -8'sd114, -8'sd116,
        -8'sd117, -8'sd118, -8'sd119, -8'sd120, -8'sd121, -8'sd122, -8'sd123, -8'sd123,
        -8'sd124, -8'sd125, -8'sd125, -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd126,
        -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd126, -8'sd125, -8'sd125,
        -8'sd124, -8'sd123, -8'sd123, -8'sd122, -8'sd121, -8'sd120, -8'sd119, -8'sd118,
        -8'sd117, -8'sd116, -8'sd114, -8'sd113, -8'sd112, -8'sd110, -8'sd108, -8'sd107,
        -8'sd105, -8'sd103, -8'sd102, -8'sd100, -8'sd98, -8'sd96, -8'sd94, -8'sd91,
        -8'sd89, -8'sd87, -8'sd85, -8'sd82, -8'sd80, -8'sd78, -8'sd75, -8'sd73,
        -8'sd70, -8'sd67, -8'sd65, -8'sd62, -8'sd59, -8'sd57, -8'sd54, -8'sd51,
        -8'sd48, -8'sd45, -8'sd42, -8'sd39, -8'sd36, -8'sd33, -8'sd30, -8'sd27,
        -8'sd24, -8'sd21, -8'sd18, -8'sd15, -8'sd12, -8'sd9, -8'sd6, -8'sd3
    };

endpackage

/* rtl/core/dsb_tick_if.sv */
// input channel carrying one sample tick item
interface dsb_tick_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink (input valid, input advance, output ready);
endinterface

/* rtl/core/dsb_result_if.sv */
// output channel carrying one duty result item
interface dsb_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       output_on;
    logic [7:0] ms_time;

    modport source (output valid, output duty, output output_on, output ms_time, input ready);
    modport sink (input valid, input duty, input output_on, input ms_time, output ready);
endinterface

/* rtl/core/dsb_apb_regs.sv */
// apb configuration register file
module dsb_apb_regs
    import dsb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output dsb_cfg_t                 cfg
);

    dsb_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_increment <= PHASE_INC_RESET;
            cfg_reg.ticks_per_ms    <= TICKS_MS_RESET;
            cfg_reg.period_ms       <= PERIOD_MS_RESET;
            cfg_reg.burst_ms        <= BURST_MS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_PHASE_INC: cfg_reg.phase_increment <= pwdata[INC_BITS-1:0];
                REG_TICKS_MS:  cfg_reg.ticks_per_ms    <= pwdata[CNT_BITS-1:0];
                REG_PERIOD_MS: cfg_reg.period_ms       <= pwdata[CNT_BITS-1:0];
                REG_BURST_MS:  cfg_reg.burst_ms        <= pwdata[CNT_BITS-1:0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PHASE_INC: prdata = cfg_reg.phase_increment;
            REG_TICKS_MS:  prdata = APB_DATA_BITS'(cfg_reg.ticks_per_ms);
            REG_PERIOD_MS: prdata = APB_DATA_BITS'(cfg_reg.period_ms);
            REG_BURST_MS:  prdata = APB_DATA_BITS'(cfg_reg.burst_ms);
            default:       prdata = '0;
        endcase
    end

endmodule

/* rtl/core/dsb_tick_core.sv */
// phase accumulator, sine lookup, ms timer and result register
module dsb_tick_core
    import dsb_pkg::*;
#(
    parameter int PHASE_BITS    = PHASE_BITS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dsb_cfg_t    cfg,
    dsb_tick_if.sink    tick,
    dsb_result_if.source result
);

    // table entries is a power of two
    localparam int ADDR_BITS = $clog2(TABLE_ENTRIES);
    localparam int USED_BITS = (ADDR_BITS < ROM_ADDR_BITS) ? ADDR_BITS : ROM_ADDR_BITS;
    localparam logic [ROM_ADDR_BITS-1:0] IDX_MASK =
        ~(ROM_ADDR_BITS'((1 << (ROM_ADDR_BITS - USED_BITS)) - 1));
    localparam int SUM_BITS = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;

    logic [PHASE_BITS-1:0]    acc_reg, acc_next;
    logic [CNT_BITS-1:0]      pre_reg, pre_next;
    logic [CNT_BITS-1:0]      ms_reg, ms_next;
    logic                     act_reg, act_next;
    logic [7:0]               duty_reg, duty_next;

    logic                     res_valid_reg, res_valid_next;
    logic [7:0]               res_duty_reg;
    logic                     res_on_reg;
    logic [CNT_BITS-1:0]      res_ms_reg;

    logic                     take;
    logic [SUM_BITS-1:0]      sum_wide;
    logic [PHASE_BITS-1:0]    acc_sum;
    logic [ROM_ADDR_BITS-1:0] rom_idx;
    logic [7:0]               tick_duty;
    logic [CNT_BITS-1:0]      pre_dec;
    logic [CNT_BITS-1:0]      ms_step;

    assign tick.ready = !res_valid_reg || result.ready;
    assign take       = tick.valid && tick.ready;

    assign sum_wide  = SUM_BITS'(acc_reg) + SUM_BITS'(cfg.phase_increment);
    assign acc_sum   = sum_wide[PHASE_BITS-1:0];
    assign rom_idx   = acc_sum[PHASE_BITS-1 -: ROM_ADDR_BITS] & IDX_MASK;
    assign tick_duty = DUTY_MID + SINE_ROM[rom_idx];
    assign pre_dec   = pre_reg - 8'd1;
    assign ms_step   = (pre_dec == '0) ? (ms_reg + 8'd1) : ms_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        pre_next  = pre_reg;
        ms_next   = ms_reg;
        act_next  = act_reg;
        duty_next = duty_reg;
        if (take && tick.advance)
        begin
            duty_next = tick_duty;
            pre_next  = (pre_dec == '0) ? cfg.ticks_per_ms : pre_dec;
            ms_next   = ms_step;
            acc_next  = acc_sum;
            if (ms_step == cfg.period_ms)
            begin
                ms_next  = '0;
                acc_next = '0;
                act_next = 1'b1;
            end
            if (ms_next == cfg.burst_ms)
            begin
                act_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pre_reg       <= TICKS_MS_RESET;
            ms_reg        <= '0;
            act_reg       <= 1'b0;
            duty_reg      <= DUTY_MID;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pre_reg       <= pre_next;
            ms_reg        <= ms_next;
            act_reg       <= act_next;
            duty_reg      <= duty_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_duty_reg <= duty_next;
            res_on_reg   <= act_next;
            res_ms_reg   <= ms_next;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.duty      = res_duty_reg;
    assign result.output_on = res_on_reg;
    assign result.ms_time   = res_ms_reg;

endmodule

/* rtl/core/dds_sine_burst_generator_unit.sv */
// top level of the dds sine burst generator
//
// tick channel: one item per sample tick, advance high moves the generator,
// advance low only reports the current state again
// result channel: one item per tick item with the pwm duty (128 plus the
// sine sample), output_on for the burst gate and ms_time within the period
// apb port: phase_increment at 0x0, ticks_per_ms at 0x4, period_ms at 0x8,
// burst_ms at 0xc; pready is always high, write only while idle
// latency: the result of a tick item is valid in the cycle after acceptance
// throughput: one item per cycle while the receiver keeps result ready, set by
// the single result register that sits after the accumulator add and sine table lookup
// reset: accumulator and ms count cleared, prescaler at 62, output off,
// held duty 128, registers at their defaults, no result pending
// stall: while a result waits, a new tick item is taken in the same cycle
// the receiver takes the waiting one; otherwise tick ready stays low
module dds_sine_burst_generator_unit
    import dsb_pkg::*;
#(
    parameter int PHASE_BITS    = PHASE_BITS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    dsb_tick_if.sink                 tick,
    dsb_result_if.source             result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    dsb_cfg_t cfg;

    dsb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsb_tick_core #(
        .PHASE_BITS    (PHASE_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .result (result)
    );

endmodule

/* rtl/core/dsb_checker.sv */
// port level checks for the dds sine burst generator
module dsb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_duty,
    input logic       res_on,
    input logic [7:0] res_ms
);

    a_take_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> res_valid
    ) else $error("accepted tick item gave no result item");

    a_stall_blocks_tick: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !tick_ready
    ) else $error("tick item taken while result item stalled");

    a_duty_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> res_duty != 8'd0
    ) else $error("duty out of range");

    a_stall_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_duty)
            && $stable(res_on) && $stable(res_ms)
    ) else $error("stalled result item changed");

endmodule

bind dds_sine_burst_generator_unit dsb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_duty   (result.duty),
    .res_on     (result.output_on),
    .res_ms     (result.ms_time)
);
